@@ src/pgmt_pkg.sv @@
`timescale 1ns / 1ps

package pgmt_pkg;

  localparam int unsigned GridCells = 16;

  localparam logic [8:0]  FilterWeightReset = 9'd230;
  localparam logic [8:0]  FilterWeightMax   = 9'd256;
  localparam logic [16:0] ThresholdReset    = 17'd65536;
  localparam logic [16:0] LevelFull         = 17'd65536;
  localparam logic [9:0]  RawRampStart      = 10'd512;
  localparam logic [9:0]  RawRampEnd        = 10'd768;

  typedef enum logic {
    CFG_FILTER_WEIGHT    = 1'b0,
    CFG_DETECT_THRESHOLD = 1'b1
  } cfg_reg_e;

  // Motion contribution of one pair of neighbor cells, indexed by
  // {before(b), before(a), now(b), now(a)}.
  localparam logic signed [1:0] MotionTable [16] = '{
    2'sd0,  2'sd1,  -2'sd1, 2'sd0,
    -2'sd1, 2'sd0,  2'sd1,  2'sd1,
    2'sd1,  -2'sd1, 2'sd0,  -2'sd1,
    2'sd0,  -2'sd1, 2'sd1,  2'sd0
  };

  typedef struct packed {
    logic               quad_row;
    logic               quad_col;
    logic signed [17:0] motion_x;
    logic signed [17:0] motion_y;
    logic signed [17:0] motion_z;
  } result_t;

  function automatic logic signed [1:0] pair_motion(
    input logic [15:0] now_v,
    input logic [15:0] bef_v,
    input logic [3:0]  a,
    input logic [3:0]  b
  );
    logic [3:0] idx;
    idx = {bef_v[b], bef_v[a], now_v[b], now_v[a]};
    return MotionTable[idx];
  endfunction

  // s * 32768 / 3, truncated toward zero, for s in -6..6.
  function automatic logic signed [17:0] third_step(input logic signed [3:0] s);
    logic [2:0]  mag;
    logic [17:0] val;
    mag = s[3] ? 3'(-s) : s[2:0];
    case (mag)
      3'd0: val = 18'd0;
      3'd1: val = 18'd10922;
      3'd2: val = 18'd21845;
      3'd3: val = 18'd32768;
      3'd4: val = 18'd43690;
      3'd5: val = 18'd54613;
      3'd6: val = 18'd65536;
      default: val = 18'd0;
    endcase
    return s[3] ? -signed'(val) : signed'(val);
  endfunction

endpackage

@@ src/proximity_grid_motion_tracker_core.sv @@
`timescale 1ns / 1ps
// A cell reading is registered on acceptance and updates the cell state from that register;
// the four quadrant results of a frame-closing reading load a four-entry result buffer.
// Throughput: one reading per cycle unless stalled; results leave at one per cycle while
// the receiver is ready, and a frame-closing reading holds until that buffer is empty.
// Reset clears all cell state and loads the register defaults (weight 230, threshold 65536).
module proximity_grid_motion_tracker_core
  import pgmt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cell_row, [3:2] cell_col, [13:4] raw_sample, [15:14] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] quad_row, [1] quad_col, [19:2] motion_x, [37:20] motion_y, [55:38] motion_z
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [8:0]  weight_q;
  logic [16:0] thresh_q;

  logic        in_valid_q;
  logic [1:0]  row_q;
  logic [1:0]  col_q;
  logic [9:0]  raw_q;
  logic        close_q;

  logic [16:0]        level_q [GridCells];
  logic signed [17:0] chg_q   [GridCells];
  logic [15:0]        now_q;
  logic [15:0]        bef_q;

  result_t     res_q [4];
  result_t     res_d [4];
  logic [2:0]  cnt_q;
  logic [1:0]  idx_q;

  logic        adv;
  logic        load;
  logic        out_take;

  logic [3:0]         cell_idx;
  logic [8:0]         k;
  logic [8:0]         d;
  logic [16:0]        scaled;
  logic [16:0]        old_lvl;
  logic signed [17:0] diff;
  logic signed [27:0] acc;
  logic [16:0]        fresh;
  logic signed [17:0] change;

  // Stall the whole front end while a closed frame waits for the result buffer.
  assign load          = close_q && (cnt_q == 3'd0);
  assign adv           = !close_q || load;
  assign s_axis_tready = adv;
  assign out_take      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= FilterWeightReset;
      thresh_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_FILTER_WEIGHT:    weight_q <= cfg_wdata_i[8:0];
        CFG_DETECT_THRESHOLD: thresh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      row_q <= s_axis_tdata[1:0];
      col_q <= s_axis_tdata[3:2];
      raw_q <= s_axis_tdata[13:4];
    end
  end

  // Cell update: scale, low-pass as scaled*256 + (old - scaled)*k, then detect.
  always_comb begin
    cell_idx = {row_q, col_q};
    k        = (weight_q > FilterWeightMax) ? FilterWeightMax : weight_q;
    d        = {raw_q[7:0], 1'b0};
    if (raw_q >= RawRampEnd) begin
      scaled = 17'd0;
    end else if (raw_q < RawRampStart) begin
      scaled = LevelFull;
    end else begin
      scaled = LevelFull - ({1'b0, d, 7'd0} | {10'd0, d[8:2]});
    end
    old_lvl = level_q[cell_idx];
    diff    = signed'({1'b0, old_lvl}) - signed'({1'b0, scaled});
    acc     = signed'({3'd0, scaled, 8'd0}) + diff * signed'({1'b0, k});
    fresh   = acc[24:8];
    change  = signed'({1'b0, fresh}) - signed'({1'b0, old_lvl});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_q <= 1'b0;
      now_q   <= '0;
      bef_q   <= '0;
      for (int i = 0; i < GridCells; i++) begin
        level_q[i] <= '0;
        chg_q[i]   <= '0;
      end
    end else if (adv) begin
      close_q <= in_valid_q && (row_q == 2'd3) && (col_q == 2'd3);
      if (in_valid_q) begin
        level_q[cell_idx] <= fresh;
        chg_q[cell_idx]   <= change;
        bef_q[cell_idx]   <= now_q[cell_idx];
        now_q[cell_idx]   <= ({15'd0, scaled} < {15'd0, thresh_q});
      end
    end
  end

  // Quadrant results from the state left by the frame-closing reading.
  always_comb begin
    logic signed [2:0]  mx [3];
    logic signed [2:0]  my [3];
    logic signed [3:0]  sx;
    logic signed [3:0]  sy;
    logic signed [19:0] zsum;
    logic signed [19:0] zadj;
    logic [3:0]         c;
    for (int q = 0; q < 4; q++) begin
      for (int t = 0; t < 3; t++) begin
        mx[t] = 3'(pair_motion(now_q, bef_q, 4'((q / 2) * 8 + t), 4'((q / 2) * 8 + t + 1)))
              + 3'(pair_motion(now_q, bef_q, 4'((q / 2) * 8 + 4 + t),
                               4'((q / 2) * 8 + 4 + t + 1)));
        my[t] = 3'(pair_motion(now_q, bef_q, 4'(t * 4 + (q % 2) * 2),
                               4'((t + 1) * 4 + (q % 2) * 2)))
              + 3'(pair_motion(now_q, bef_q, 4'(t * 4 + (q % 2) * 2 + 1),
                               4'((t + 1) * 4 + (q % 2) * 2 + 1)));
      end
      sx = ((q % 2) == 0) ? (4'(mx[0]) <<< 1) + 4'(mx[1]) : 4'(mx[1]) + (4'(mx[2]) <<< 1);
      sy = ((q / 2) == 0) ? (4'(my[0]) <<< 1) + 4'(my[1]) : 4'(my[1]) + (4'(my[2]) <<< 1);
      zsum = '0;
      for (int kk = 0; kk < 2; kk++) begin
        for (int ll = 0; ll < 2; ll++) begin
          c = 4'(((q / 2) * 2 + kk) * 4 + (q % 2) * 2 + ll);
          if (now_q[c] && bef_q[c]) begin
            zsum = zsum + 20'(chg_q[c]);
          end
        end
      end
      // Round toward zero on the divide by four.
      zadj = zsum + (zsum[19] ? 20'sd3 : 20'sd0);
      res_d[q].quad_row = 1'(q / 2);
      res_d[q].quad_col = 1'(q % 2);
      res_d[q].motion_x = third_step(sx);
      res_d[q].motion_y = third_step(sy);
      res_d[q].motion_z = zadj[19:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load) begin
      cnt_q <= 3'd4;
      idx_q <= '0;
    end else if (out_take) begin
      cnt_q <= cnt_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int q = 0; q < 4; q++) begin
        res_q[q] <= res_d[q];
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tlast  = (idx_q == 2'd3);
  assign m_axis_tdata  = {res_q[idx_q].motion_z, res_q[idx_q].motion_y,
                          res_q[idx_q].motion_x, res_q[idx_q].quad_col,
                          res_q[idx_q].quad_row};

endmodule

@@ src/pgmt_checker.sv @@
`timescale 1ns / 1ps
module pgmt_checker
  import pgmt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // A frame's four results leave as one unbroken burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a frame's results");

  // Last result of a frame is the lower right quadrant, and only that one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'b11)))
    else $error("frame end not on lower right quadrant");

  // Quadrants come out in order {row, col} within a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      {m_axis_tdata[0], m_axis_tdata[1]} ==
        2'({$past(m_axis_tdata[0]), $past(m_axis_tdata[1])} + 2'd1))
    else $error("quadrant order broken");

endmodule

bind proximity_grid_motion_tracker_core pgmt_checker u_pgmt_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import pgmt_pkg::*;

  typedef struct packed {
    logic               quad_row;
    logic               quad_col;
    logic signed [17:0] motion_x;
    logic signed [17:0] motion_y;
    logic signed [17:0] motion_z;
    logic               frame_end;
  } quad_motion_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_reg_e    reg_idx;
    logic [16:0] wval;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [9:0]  raw;
    logic        all_zero;
  } dir_step_t;

  // Neighbor pair step, indexed by {prev(b), prev(a), now(b), now(a)}.
  localparam int PairMotion [16] = '{0, 1, -1, 0, -1, 0, 1, 1, 1, -1, 0, -1, 0, -1, 1, 0};

  localparam int NumDir = 25;
  localparam dir_step_t DirTable [NumDir] = '{
    // nothing was ever detected after reset: every quadrant reads zero
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd3, 2'd3, 10'd0,    1'b1},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd0, 2'd0, 10'd1023, 1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd0, 2'd1, 10'd768,  1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd0, 2'd2, 10'd767,  1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd0, 2'd3, 10'd512,  1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd1, 2'd0, 10'd511,  1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd1, 2'd1, 10'd682,  1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd1, 2'd2, 10'd341,  1'b0},
    // same cell again within the frame
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd1, 2'd1, 10'd700,  1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd2, 2'd1, 10'd640,  1'b0},
    // close with seven of the sixteen cells missing
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd3, 2'd3, 10'd1023, 1'b0},
    '{1'b1, CFG_FILTER_WEIGHT,    17'd0,      2'd0, 2'd0, 10'd0,    1'b0},
    '{1'b1, CFG_DETECT_THRESHOLD, 17'd0,      2'd0, 2'd0, 10'd0,    1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd2, 2'd2, 10'd513,  1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd3, 2'd3, 10'd600,  1'b0},
    '{1'b1, CFG_FILTER_WEIGHT,    17'd256,    2'd0, 2'd0, 10'd0,    1'b0},
    '{1'b1, CFG_DETECT_THRESHOLD, 17'd131071, 2'd0, 2'd0, 10'd0,    1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd2, 2'd2, 10'd1023, 1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd3, 2'd3, 10'd1023, 1'b0},
    // weight above full scale clamps to a held level
    '{1'b1, CFG_FILTER_WEIGHT,    17'd511,    2'd0, 2'd0, 10'd0,    1'b0},
    '{1'b1, CFG_DETECT_THRESHOLD, 17'd65537,  2'd0, 2'd0, 10'd0,    1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd1, 2'd1, 10'd0,    1'b0},
    '{1'b0, CFG_FILTER_WEIGHT,    17'd0,      2'd3, 2'd3, 10'd700,  1'b0},
    '{1'b1, CFG_FILTER_WEIGHT,    17'd230,    2'd0, 2'd0, 10'd0,    1'b0},
    '{1'b1, CFG_DETECT_THRESHOLD, 17'd65536,  2'd0, 2'd0, 10'd0,    1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [16:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [1:0] cell_row, [3:2] cell_col, [13:4] raw_sample, [15:14] zero
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] quad_row, [1] quad_col, [19:2] motion_x, [37:20] motion_y, [55:38] motion_z
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned  weight_q;
  int unsigned  thresh_q;
  int           level_q [16];
  int           change_q [16];
  bit           now_q [16];
  bit           prev_q [16];
  quad_motion_t quad_motion_q [$];

  logic [9:0] cell_raw [16];
  int         n_fail;
  int         cells_sent;
  bit         send_burst;
  bit         recv_burst;
  bit         long_hold;

  proximity_grid_motion_tracker_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic int scaled_level(logic [9:0] raw);
    int d;
    if (raw >= RawRampEnd) return 0;
    if (raw < RawRampStart) return int'(LevelFull);
    d = (int'(raw) - int'(RawRampStart)) * 2;
    return int'(LevelFull) - ((d << 7) | (d >> 2));
  endfunction

  function automatic int pair_step(int a, int b);
    return PairMotion[{prev_q[b], prev_q[a], now_q[b], now_q[a]}];
  endfunction

  // Update one cell; on the closing cell, queue the four quadrant results.
  task automatic track_cell(logic [1:0] row, logic [1:0] col, logic [9:0] raw,
                            bit all_zero);
    int cell_idx, k, lvl, fresh, x, y, z, cidx;
    int m [3];
    quad_motion_t res;
    cell_idx = int'(row) * 4 + int'(col);
    k = (weight_q > FilterWeightMax) ? 256 : int'(weight_q);
    lvl = scaled_level(raw);
    fresh = (level_q[cell_idx] * k + lvl * (256 - k)) / 256;
    change_q[cell_idx] = fresh - level_q[cell_idx];
    level_q[cell_idx] = fresh;
    prev_q[cell_idx] = now_q[cell_idx];
    now_q[cell_idx] = lvl < int'(thresh_q);
    if (row == 2'd3 && col == 2'd3) begin
      for (int qr = 0; qr < 2; qr++) begin
        for (int qc = 0; qc < 2; qc++) begin
          for (int t = 0; t < 3; t++) begin
            m[t] = (pair_step(qr * 8 + t, qr * 8 + t + 1) +
                    pair_step(qr * 8 + 4 + t, qr * 8 + 5 + t)) * 32768;
          end
          x = (qc == 0) ? (m[0] * 2 + m[1]) / 3 : (m[1] + m[2] * 2) / 3;
          for (int t = 0; t < 3; t++) begin
            m[t] = (pair_step(t * 4 + qc * 2, (t + 1) * 4 + qc * 2) +
                    pair_step(t * 4 + qc * 2 + 1, (t + 1) * 4 + qc * 2 + 1)) * 32768;
          end
          y = (qr == 0) ? (m[0] * 2 + m[1]) / 3 : (m[1] + m[2] * 2) / 3;
          z = 0;
          for (int kk = 0; kk < 2; kk++) begin
            for (int ll = 0; ll < 2; ll++) begin
              cidx = (qr * 2 + kk) * 4 + qc * 2 + ll;
              if (now_q[cidx] && prev_q[cidx]) z += change_q[cidx];
            end
          end
          z = z / 4;
          if (all_zero) begin
            x = 0;
            y = 0;
            z = 0;
          end
          res.quad_row  = qr[0];
          res.quad_col  = qc[0];
          res.motion_x  = 18'(x);
          res.motion_y  = 18'(y);
          res.motion_z  = 18'(z);
          res.frame_end = (qr == 1 && qc == 1);
          quad_motion_q.push_back(res);
        end
      end
    end
  endtask

  task automatic send_cell(logic [1:0] row, logic [1:0] col, logic [9:0] raw,
                           bit all_zero);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, raw, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    track_cell(row, col, raw, all_zero);
    cells_sent++;
  endtask

  // Drop the request and let every pending result leave the block.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (quad_motion_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [16:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FILTER_WEIGHT) weight_q = val[8:0];
    else thresh_q = val;
    @(posedge clk_i);
  endtask

  function automatic logic [9:0] pick_raw();
    case ($urandom_range(0, 3))
      0: return 10'($urandom_range(0, 511));
      1: return 10'($urandom_range(512, 767));
      2: return 10'($urandom_range(768, 1023));
      default: return 10'($urandom);
    endcase
  endfunction

  // Raster frame; a broken one skips and repeats cells at random.
  task automatic send_frame(bit broken);
    for (int c = 0; c < 16; c++) begin
      if ($urandom_range(0, 1) == 0) cell_raw[c] = pick_raw();
      if (broken && c != 15 && $urandom_range(0, 4) == 0) continue;
      send_cell(2'(c / 4), 2'(c % 4), cell_raw[c], 1'b0);
      if (broken && $urandom_range(0, 4) == 0) begin
        send_cell(2'(c / 4), 2'(c % 4), pick_raw(), 1'b0);
      end
    end
  endtask

  task automatic new_setting();
    logic [16:0] w, t;
    case ($urandom_range(0, 5))
      0: w = 17'd0;
      1: w = 17'd256;
      2: w = 17'($urandom_range(257, 511));
      3: w = 17'(FilterWeightReset);
      default: w = 17'($urandom_range(0, 256));
    endcase
    case ($urandom_range(0, 5))
      0: t = 17'd0;
      1: t = ThresholdReset;
      2: t = 17'd65537;
      3: t = 17'd131071;
      4: t = 17'($urandom_range(1, 65535));
      default: t = 17'($urandom);
    endcase
    drain();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_FILTER_WEIGHT, w);
      write_reg(CFG_DETECT_THRESHOLD, t);
    end else begin
      write_reg(CFG_DETECT_THRESHOLD, t);
      write_reg(CFG_FILTER_WEIGHT, w);
    end
  endtask

  task automatic check_field(string name, logic signed [17:0] want,
                             logic signed [17:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      n_fail++;
    end
  endtask

  task automatic check_motion();
    quad_motion_t want;
    if (quad_motion_q.size() == 0) begin
      $error("motion result with none pending: tdata %h", m_axis_tdata);
      n_fail++;
    end else begin
      want = quad_motion_q.pop_front();
      check_field("quad_row", 18'(want.quad_row), 18'(m_axis_tdata[0]));
      check_field("quad_col", 18'(want.quad_col), 18'(m_axis_tdata[1]));
      check_field("motion_x", want.motion_x, $signed(m_axis_tdata[19:2]));
      check_field("motion_y", want.motion_y, $signed(m_axis_tdata[37:20]));
      check_field("motion_z", want.motion_z, $signed(m_axis_tdata[55:38]));
      check_field("frame_end", 18'(want.frame_end), 18'(m_axis_tlast));
    end
  endtask

  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 17);
      // one long hold-off so the result buffer fills and stalls the input
      if (long_hold) begin
        gap = 400;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_motion();
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_FILTER_WEIGHT;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    weight_q = FilterWeightReset;
    thresh_q = ThresholdReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDir; i++) begin
      if (DirTable[i].is_cfg) begin
        drain();
        write_reg(DirTable[i].reg_idx, DirTable[i].wval);
      end else begin
        send_cell(DirTable[i].row, DirTable[i].col, DirTable[i].raw,
                  DirTable[i].all_zero);
      end
    end

    for (int c = 0; c < 16; c++) cell_raw[c] = pick_raw();

    // hold the receiver off while further frames keep arriving
    send_frame(1'b0);
    long_hold = 1'b1;
    send_frame(1'b0);
    send_frame(1'b0);

    while (cells_sent < 290) begin
      new_setting();
      repeat (3) begin
        case ($urandom_range(0, 9))
          0: send_frame(1'b1);
          1: begin
            repeat ($urandom_range(1, 6)) begin
              send_cell(2'($urandom), 2'($urandom), 10'($urandom), 1'b0);
            end
          end
          default: send_frame(1'b0);
        endcase
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
src/pgmt_pkg.sv
src/proximity_grid_motion_tracker_core.sv
src/pgmt_checker.sv
dv/tb.sv
